// ===== design/pdtd_pkg.sv =====
// Package for the periodic and run-once task dispatcher.
// Holds sizes, codes, sequencer states and the structs between modules; no dependencies.
`timescale 1ns / 1ps

package pdtd_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_RESULTS = 32;

   localparam int SLOT_IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int SLOT_CNT_W  = $clog2(TABLE_SLOTS + 1);
   localparam int QUEUE_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] FUNC_ADD  = 2'd0;
   localparam logic [1:0] FUNC_PUSH = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_RUN    = 2'd1;
   localparam logic [1:0] KIND_IDLE   = 2'd2;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_REJECT = 2'd1;
   localparam logic [1:0] STAT_QFULL  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DRAIN  = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic       push;
      logic [7:0] push_id;
      logic       pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] fill;
      logic [7:0]             head_id;
   } queue_stat_type;

   typedef struct packed {
      logic        add;
      logic [7:0]  add_id;
      logic [31:0] add_period;
      logic        start;
      logic        step;
      logic [31:0] now;
   } slot_ctrl_type;

   typedef struct packed {
      logic [SLOT_CNT_W-1:0] count;
      logic                  more;
      logic                  due;
      logic [7:0]            id;
   } slot_stat_type;

endpackage

// ===== design/periodic_and_once_task_dispatcher.sv =====
// Top level of the task dispatcher: sequencer, pending result and output register.
// Depends on pdtd_pkg, pdtd_queue and pdtd_slots.
//
// Add and push beats place their status reply in the output register. During a
// tick, while the result side never stalls, the queue read port drains one id per
// cycle, then the table read port and its single subtract-and-compare unit check
// one slot per cycle; a step to enter the scan lies between the two, and a closing
// step ends the run. Run results come out one beat behind their discovery so the
// final one carries last_of_run; a tick with no task due gives one idle beat.
// req_ready is low while a tick is in progress and while the output register
// holds a beat that is not being taken.
`timescale 1ns / 1ps

module periodic_and_once_task_dispatcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_task_id,
   input  logic [31:0] req_period,
   input  logic [31:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_run_id,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_of_run
);

   pdtd_pkg::state_type      state_ff, state_in;
   pdtd_pkg::queue_ctrl_type qctrl;
   pdtd_pkg::queue_stat_type qstat;
   pdtd_pkg::slot_ctrl_type  sctrl;
   pdtd_pkg::slot_stat_type  sstat;

   logic [31:0]                    now_ff, now_in;
   logic [pdtd_pkg::RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [7:0]                     pend_id_ff, pend_id_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_kind_ff, rsp_kind_in;
   logic [7:0]                     rsp_run_id_ff, rsp_run_id_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           out_free;
   logic                           budget_ok;
   logic                           cand;
   logic [7:0]                     cand_id;

   pdtd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctrl  (qctrl),
      .stat  (qstat)
   );

   pdtd_slots u_slots (
      .clock (clock),
      .reset (reset),
      .ctrl  (sctrl),
      .stat  (sstat)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == pdtd_pkg::ST_IDLE) && out_free;
   assign budget_ok = res_cnt_ff < pdtd_pkg::RES_CNT_W'(pdtd_pkg::MAX_RESULTS);

   always_comb begin
      state_in         = state_ff;
      now_in           = now_ff;
      res_cnt_in       = res_cnt_ff;
      pend_valid_in    = pend_valid_ff;
      pend_id_in       = pend_id_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_kind_in      = rsp_kind_ff;
      rsp_run_id_in    = rsp_run_id_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_last_in      = rsp_last_ff;
      qctrl.push       = 1'b0;
      qctrl.push_id    = req_task_id;
      qctrl.pop        = 1'b0;
      sctrl.add        = 1'b0;
      sctrl.add_id     = req_task_id;
      sctrl.add_period = req_period;
      sctrl.start      = state_ff != pdtd_pkg::ST_SCAN;
      sctrl.step       = 1'b0;
      sctrl.now        = now_ff;
      cand             = 1'b0;
      cand_id          = '0;

      case (state_ff)
         pdtd_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_func)
                  pdtd_pkg::FUNC_ADD: begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = pdtd_pkg::KIND_STATUS;
                     rsp_run_id_in = '0;
                     rsp_last_in   = 1'b1;
                     if (req_task_id != 8'd0 &&
                         sstat.count < pdtd_pkg::SLOT_CNT_W'(pdtd_pkg::TABLE_SLOTS)) begin
                        sctrl.add     = 1'b1;
                        rsp_status_in = pdtd_pkg::STAT_OK;
                     end else begin
                        rsp_status_in = pdtd_pkg::STAT_REJECT;
                     end
                  end
                  pdtd_pkg::FUNC_PUSH: begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = pdtd_pkg::KIND_STATUS;
                     rsp_run_id_in = '0;
                     rsp_last_in   = 1'b1;
                     if (qstat.fill < pdtd_pkg::QUEUE_CNT_W'(pdtd_pkg::QUEUE_DEPTH)) begin
                        qctrl.push    = 1'b1;
                        rsp_status_in = pdtd_pkg::STAT_OK;
                     end else begin
                        rsp_status_in = pdtd_pkg::STAT_QFULL;
                     end
                  end
                  pdtd_pkg::FUNC_TICK: begin
                     now_in     = req_now_time;
                     res_cnt_in = '0;
                     state_in   = pdtd_pkg::ST_DRAIN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pdtd_pkg::ST_DRAIN: begin
            if (out_free) begin
               if (qstat.fill != '0 && budget_ok) begin
                  qctrl.pop = 1'b1;
                  cand      = qstat.head_id != 8'd0;
                  cand_id   = qstat.head_id;
               end else begin
                  state_in = pdtd_pkg::ST_SCAN;
               end
            end
         end
         pdtd_pkg::ST_SCAN: begin
            if (out_free) begin
               if (sstat.more && budget_ok) begin
                  sctrl.step = 1'b1;
                  cand       = sstat.due;
                  cand_id    = sstat.id;
               end else begin
                  state_in = pdtd_pkg::ST_FINISH;
               end
            end
         end
         pdtd_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pdtd_pkg::STAT_OK;
               rsp_last_in   = 1'b1;
               if (pend_valid_ff) begin
                  rsp_kind_in   = pdtd_pkg::KIND_RUN;
                  rsp_run_id_in = pend_id_ff;
               end else begin
                  rsp_kind_in   = pdtd_pkg::KIND_IDLE;
                  rsp_run_id_in = '0;
               end
               pend_valid_in = 1'b0;
               state_in      = pdtd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pdtd_pkg::ST_IDLE;
         end
      endcase

      // hold the newest run id back one beat; release the older one
      if (cand) begin
         res_cnt_in    = res_cnt_ff + pdtd_pkg::RES_CNT_W'(1);
         pend_valid_in = 1'b1;
         pend_id_in    = cand_id;
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = pdtd_pkg::KIND_RUN;
            rsp_run_id_in = pend_id_ff;
            rsp_status_in = pdtd_pkg::STAT_OK;
            rsp_last_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pdtd_pkg::ST_IDLE;
         res_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         res_cnt_ff    <= res_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      pend_id_ff    <= pend_id_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_run_id_ff <= rsp_run_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_run_id      = rsp_run_id_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == pdtd_pkg::ST_IDLE |-> !pend_valid_ff)
      else $error("pending run id left over in idle");

   a_budget: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= pdtd_pkg::RES_CNT_W'(pdtd_pkg::MAX_RESULTS))
      else $error("result budget exceeded");

   a_finish_emits_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pdtd_pkg::ST_FINISH && out_free) |=>
      (rsp_valid_ff && rsp_last_ff && state_ff == pdtd_pkg::ST_IDLE))
      else $error("tick closed without a final beat");

   a_run_id_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == pdtd_pkg::KIND_RUN) |-> rsp_run_id_ff != 8'd0)
      else $error("run beat carries id zero");

endmodule

// ===== design/pdtd_queue.sv =====
// Ring FIFO of run-once task ids with a registered read of the head entry.
// Depends on pdtd_pkg.
`timescale 1ns / 1ps

module pdtd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  pdtd_pkg::queue_ctrl_type ctrl,
   output pdtd_pkg::queue_stat_type stat
);

   logic [7:0] mem [pdtd_pkg::QUEUE_DEPTH];

   logic [pdtd_pkg::QUEUE_IDX_W-1:0] head_ff, head_in, head_nxt;
   logic [pdtd_pkg::QUEUE_IDX_W-1:0] tail_ff, tail_in, tail_nxt;
   logic [pdtd_pkg::QUEUE_CNT_W-1:0] fill_ff, fill_in;
   logic [7:0]                       rd_ff;

   always_comb begin
      head_nxt = (head_ff == pdtd_pkg::QUEUE_IDX_W'(pdtd_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : head_ff + pdtd_pkg::QUEUE_IDX_W'(1);
      tail_nxt = (tail_ff == pdtd_pkg::QUEUE_IDX_W'(pdtd_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : tail_ff + pdtd_pkg::QUEUE_IDX_W'(1);
      head_in  = ctrl.pop ? head_nxt : head_ff;
      tail_in  = ctrl.push ? tail_nxt : tail_ff;
      fill_in  = fill_ff;
      if (ctrl.push) begin
         fill_in = fill_ff + pdtd_pkg::QUEUE_CNT_W'(1);
      end else if (ctrl.pop) begin
         fill_in = fill_ff - pdtd_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= ctrl.push_id;
      end
      rd_ff <= mem[head_in];
   end

   assign stat.fill    = fill_ff;
   assign stat.head_id = rd_ff;

endmodule

// ===== design/pdtd_slots.sv =====
// Periodic task table: id, period and last run time memories, scan index and the
// shared wrapping subtract-and-compare unit. Depends on pdtd_pkg.
`timescale 1ns / 1ps

module pdtd_slots (
   input  logic                   clock,
   input  logic                   reset,
   input  pdtd_pkg::slot_ctrl_type ctrl,
   output pdtd_pkg::slot_stat_type stat
);

   logic [7:0]  ids   [pdtd_pkg::TABLE_SLOTS];
   logic [31:0] pers  [pdtd_pkg::TABLE_SLOTS];
   logic [31:0] lasts [pdtd_pkg::TABLE_SLOTS];

   logic [pdtd_pkg::SLOT_CNT_W-1:0] count_ff, count_in;
   logic [pdtd_pkg::SLOT_CNT_W-1:0] idx_ff, idx_in;
   logic [pdtd_pkg::SLOT_IDX_W-1:0] rd_addr;
   logic [7:0]                      rd_id_ff;
   logic [31:0]                     rd_per_ff;
   logic [31:0]                     rd_last_ff;
   logic [31:0]                     elapsed;

   always_comb begin
      count_in = ctrl.add ? count_ff + pdtd_pkg::SLOT_CNT_W'(1) : count_ff;
      if (ctrl.start) begin
         idx_in = '0;
      end else if (ctrl.step) begin
         idx_in = idx_ff + pdtd_pkg::SLOT_CNT_W'(1);
      end else begin
         idx_in = idx_ff;
      end
      rd_addr = idx_in[pdtd_pkg::SLOT_IDX_W-1:0];
      elapsed = ctrl.now - rd_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.add) begin
         ids[count_ff[pdtd_pkg::SLOT_IDX_W-1:0]]  <= ctrl.add_id;
         pers[count_ff[pdtd_pkg::SLOT_IDX_W-1:0]] <= ctrl.add_period;
      end
      if (ctrl.add) begin
         lasts[count_ff[pdtd_pkg::SLOT_IDX_W-1:0]] <= '0;
      end else if (ctrl.step && stat.due) begin
         lasts[idx_ff[pdtd_pkg::SLOT_IDX_W-1:0]] <= ctrl.now;
      end
      rd_id_ff   <= ids[rd_addr];
      rd_per_ff  <= pers[rd_addr];
      rd_last_ff <= lasts[rd_addr];
   end

   assign stat.count = count_ff;
   assign stat.more  = idx_ff < count_ff;
   assign stat.due   = elapsed >= rd_per_ff;
   assign stat.id    = rd_id_ff;

endmodule
